/* src/imudr_pkg.sv */
// Shared types, constants and fixed-point helpers of the IMU dead-reckoning integrator.
package imudr_pkg;

	// Shared arithmetic unit widths.
	localparam int RES_W  = 66;  // signed result and operand A width
	localparam int B_W    = 34;  // signed operand B width
	localparam int MC_W   = 54;  // multiplicand magnitude bits
	localparam int ML_W   = 54;  // multiplier register bits, reciprocal width
	localparam int MB_W   = 33;  // multiplier bits of a plain product, one per cycle
	localparam int NUM_W  = 62;  // dividend magnitude bits
	localparam int DIV_W  = 21;  // rounding offset width
	localparam int CNT_W  = 6;   // step counter width

	// Datapath widths.
	localparam int R_W     = 34; // rotation matrix entry, signed Q27
	localparam int DELTA_W = 42; // per-step increments
	localparam int SUM_W   = 40; // rotated acceleration partial sum

	// Arithmetic unit operation codes.
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	// Fixed-point constants.
	localparam logic signed [R_W-1:0] Q27_ONE = 34'sd134217728;
	localparam logic [DIV_W-1:0] HALF_ONE  = 21'd500000;
	localparam logic [DIV_W-1:0] HALF_TWO  = 21'd1000000;

	// A million is 2^6 times 15625; the odd part is divided by a reciprocal in Q67.
	localparam int          USEC_SH  = 6;
	localparam int          REC_SH   = 67;
	localparam logic [67:0] USEC_ODD = 68'd15625;
	localparam logic [67:0] RECIP_FULL = ((68'd1 << REC_SH) / USEC_ODD) + 68'd1;
	localparam logic [ML_W-1:0] RECIP  = RECIP_FULL[ML_W-1:0];

	// Configuration register indexes.
	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_SCAN    = 2'd1;
	localparam logic [1:0] REG_GRAVITY = 2'd2;

	// Configuration reset values.
	localparam logic [23:0] SCAN_RESET    = 24'd100000;
	localparam logic [20:0] GRAVITY_RESET = 21'd642908;

	// One request to the shared arithmetic unit.
	typedef struct packed {
		logic start;
		logic op;
		logic div2;
	} alu_req_t;

	// Round half up, then drop 27 fraction bits.
	function automatic logic signed [RES_W-1:0] round27(input logic signed [RES_W-1:0] v);
		logic signed [RES_W-1:0] t;
		begin
			t = v + (66'sd1 <<< 26);
			return t >>> 27;
		end
	endfunction

	// True when the value lies outside the 32-bit signed range.
	function automatic logic ovf32(input logic signed [RES_W-1:0] v);
		return (v > 66'sd2147483647) || (v < -66'sd2147483648);
	endfunction

	// Clamp to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [RES_W-1:0] v);
		logic signed [31:0] r;
		begin
			if (v > 66'sd2147483647) begin
				r = 32'sh7fffffff;
			end else if (v < -66'sd2147483648) begin
				r = 32'sh80000000;
			end else begin
				r = v[31:0];
			end
			return r;
		end
	endfunction

endpackage

/* src/imudr_alu.sv */
// Shared shift-add multiplier, one bit per cycle, that also divides by one or two million by reciprocal.
module imudr_alu import imudr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  alu_req_t                req,
	input  logic signed [RES_W-1:0] a,
	input  logic signed [B_W-1:0]   b,
	output logic                    done,
	output logic signed [RES_W-1:0] res
);

	logic             busy_q;
	logic             done_q;
	logic             op_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MC_W:0]    hi_q;
	logic [ML_W-1:0]  lo_q;
	logic [MC_W-1:0]  mcd_q;
	logic [ML_W-1:0]  mlr_q;
	logic signed [RES_W-1:0] res_q;

	logic [RES_W-1:0] a_mag;
	logic [B_W-1:0]   b_mag;
	logic [NUM_W-1:0] num;
	logic [NUM_W-1:0] num_sc;
	logic [MC_W:0]    sum;
	logic [MC_W:0]    hi_nx;
	logic [ML_W-1:0]  lo_nx;
	logic [RES_W-1:0] mag_nx;
	logic signed [RES_W-1:0] res_nx;

	// Operand magnitudes; a division adds half the divisor and drops the power-of-two part.
	always_comb begin
		a_mag  = a[RES_W-1] ? RES_W'(-a) : RES_W'(a);
		b_mag  = b[B_W-1] ? B_W'(-b) : B_W'(b);
		num    = a_mag[NUM_W-1:0] + NUM_W'(req.div2 ? HALF_TWO : HALF_ONE);
		num_sc = req.div2 ? (num >> (USEC_SH + 1)) : (num >> USEC_SH);
	end

	// One shift-add step; low product bits move into lo_q as they settle.
	always_comb begin
		sum   = hi_q + (mlr_q[0] ? {1'b0, mcd_q} : '0);
		hi_nx = {1'b0, sum[MC_W:1]};
		lo_nx = {sum[0], lo_q[ML_W-1:1]};
		if (op_q == OP_DIV) begin
			// The quotient is the product shifted down by the reciprocal's fraction bits.
			mag_nx = RES_W'(hi_nx[MC_W:REC_SH-ML_W]);
		end else begin
			mag_nx = {hi_nx[RES_W-MB_W-1:0], lo_nx[ML_W-1 -: MB_W]};
		end
		res_nx = neg_q ? -$signed(mag_nx) : $signed(mag_nx);
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == OP_DIV) ? CNT_W'(ML_W) : CNT_W'(MB_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			hi_q <= '0;
			lo_q <= '0;
			if (req.op == OP_DIV) begin
				neg_q <= a[RES_W-1];
				mcd_q <= num_sc[MC_W-1:0];
				mlr_q <= RECIP;
			end else begin
				neg_q <= a[RES_W-1] ^ b[B_W-1];
				mcd_q <= a_mag[MC_W-1:0];
				mlr_q <= ML_W'(b_mag[MB_W-1:0]);
			end
		end else if (busy_q) begin
			hi_q  <= hi_nx;
			lo_q  <= lo_nx;
			mlr_q <= {1'b0, mlr_q[ML_W-1:1]};
			if (cnt_q == CNT_W'(1)) begin
				res_q <= res_nx;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* src/imu_dead_reckoning_integrator_core.sv */
// Top level of the IMU dead-reckoning integrator: sequencer, state and ports.
//
//  Channel | Signals                          | Direction | Payload
//  in      | in_valid / in_ready              | to block  | quaternion, accel, gyro, time_us
//  out     | out_valid / out_ready            | from block| pos, vel, rot, integrated, saturated
//  cfg     | cfg_valid / cfg_ready            | to block  | cfg_index, cfg_data
//
// An integrated sample takes 33 multiplications and 12 rounding divisions (each a
// reciprocal multiplication), all run in turn on the one bit-serial arithmetic unit.
// A held or first sample goes straight to the output state.
// in_ready is high only while idle.
// A result waits in the output register while the next request is accepted.
// Reset is asynchronous, active low; no clearing pass is needed.
module imu_dead_reckoning_integrator_core import imudr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [31:0] accel_x,
	input  logic signed [31:0] accel_y,
	input  logic signed [31:0] accel_z,
	input  logic signed [31:0] gyro_x,
	input  logic signed [31:0] gyro_y,
	input  logic signed [31:0] gyro_z,
	input  logic [47:0]        time_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] vel_z,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z,
	output logic               integrated,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_QUAT = 3'd1;
	localparam logic [2:0] ST_GRAV = 3'd2;
	localparam logic [2:0] ST_ROT  = 3'd3;
	localparam logic [2:0] ST_INT  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	// Configuration and sequencer state.
	logic        enable_q;
	logic [23:0] scan_q;
	logic [20:0] grav_q;
	logic [2:0]  st_q;
	logic        wait_q;
	logic [3:0]  k_q;
	logic [1:0]  ax_q;
	logic [1:0]  m_q;
	logic        dphase_q;
	logic        have_last_q;
	logic [47:0] last_q;
	logic        integ_q;
	logic        clip_q;
	logic        out_valid_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] ang_q [3];

	// Latched sample and working values.
	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [31:0] acc_in_q [3];
	logic signed [31:0] gyr_q [3];
	logic [23:0]        dt_q;
	logic signed [31:0] p_q [9];
	logic signed [B_W-1:0]     ac_q [3];
	logic signed [SUM_W-1:0]   s_q;
	logic signed [31:0]        aw_q;
	logic signed [DELTA_W-1:0] dv_q, pv_q, pd_q;
	logic signed [31:0] opos_q [3];
	logic signed [31:0] ovel_q [3];
	logic signed [31:0] oang_q [3];
	logic               ointeg_q;
	logic               oclip_q;

	logic        in_acc;
	logic [47:0] diff;
	logic        integ_now;
	logic        out_free;
	alu_req_t    req;
	logic signed [RES_W-1:0] alu_a;
	logic signed [B_W-1:0]   alu_b;
	logic                    alu_done;
	logic signed [RES_W-1:0] alu_res;
	logic                    step_done;
	logic signed [15:0]      qa, qb;
	logic signed [R_W-1:0]   r_m [3][3];
	logic signed [RES_W-1:0] s_next, pos_sum, vel_sum, ang_sum;

	assign in_ready  = (st_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign step_done = wait_q && alu_done;

	// Gap check against the previous timestamp.
	always_comb begin
		diff      = time_us - last_q;
		integ_now = have_last_q && (time_us >= last_q) && (diff < {24'd0, scan_q});
	end

	// Rotation matrix from the stored quaternion products.
	always_comb begin
		r_m[0][0] = Q27_ONE - (R_W'(p_q[1]) + R_W'(p_q[2]));
		r_m[0][1] = R_W'(p_q[3]) - R_W'(p_q[8]);
		r_m[0][2] = R_W'(p_q[4]) + R_W'(p_q[7]);
		r_m[1][0] = R_W'(p_q[3]) + R_W'(p_q[8]);
		r_m[1][1] = Q27_ONE - (R_W'(p_q[0]) + R_W'(p_q[2]));
		r_m[1][2] = R_W'(p_q[5]) - R_W'(p_q[6]);
		r_m[2][0] = R_W'(p_q[4]) - R_W'(p_q[7]);
		r_m[2][1] = R_W'(p_q[5]) + R_W'(p_q[6]);
		r_m[2][2] = Q27_ONE - (R_W'(p_q[0]) + R_W'(p_q[1]));
	end

	// Quaternion factor pairs, in the order xx yy zz xy xz yz wx wy wz.
	always_comb begin
		case (k_q)
			4'd0: begin qa = qx_q; qb = qx_q; end
			4'd1: begin qa = qy_q; qb = qy_q; end
			4'd2: begin qa = qz_q; qb = qz_q; end
			4'd3: begin qa = qx_q; qb = qy_q; end
			4'd4: begin qa = qx_q; qb = qz_q; end
			4'd5: begin qa = qy_q; qb = qz_q; end
			4'd6: begin qa = qw_q; qb = qx_q; end
			4'd7: begin qa = qw_q; qb = qy_q; end
			4'd8: begin qa = qw_q; qb = qz_q; end
			default: begin qa = qw_q; qb = qw_q; end
		endcase
	end

	// Operand selection for the shared unit.
	always_comb begin
		req.start = 1'b0;
		req.op    = OP_MUL;
		req.div2  = 1'b0;
		alu_a     = '0;
		alu_b     = '0;
		case (st_q)
			ST_QUAT: begin
				req.start = !wait_q;
				alu_a     = RES_W'(qa);
				alu_b     = B_W'(qb);
			end
			ST_GRAV: begin
				req.start = !wait_q;
				alu_a     = RES_W'(r_m[2][k_q[1:0]]);
				alu_b     = $signed({13'd0, grav_q});
			end
			ST_ROT: begin
				req.start = !wait_q;
				alu_a     = RES_W'(r_m[ax_q][k_q[1:0]]);
				alu_b     = ac_q[k_q[1:0]];
			end
			ST_INT: begin
				req.start = !wait_q;
				alu_b     = $signed({10'd0, dt_q});
				if (dphase_q) begin
					req.op   = OP_DIV;
					req.div2 = (m_q == 2'd2);
					alu_a    = alu_res;
				end else begin
					case (m_q)
						2'd0:    alu_a = RES_W'(aw_q);
						2'd1:    alu_a = RES_W'(vel_q[ax_q]);
						2'd2:    alu_a = RES_W'(dv_q);
						default: alu_a = RES_W'(gyr_q[ax_q]);
					endcase
				end
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	// Sums formed when a step completes.
	always_comb begin
		s_next  = RES_W'(s_q) + round27(alu_res);
		pos_sum = RES_W'(pos_q[ax_q]) + RES_W'(pv_q) + RES_W'(pd_q);
		vel_sum = RES_W'(vel_q[ax_q]) + RES_W'(dv_q);
		ang_sum = RES_W'(ang_q[ax_q]) + alu_res;
	end

	imudr_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (alu_a),
		.b      (alu_b),
		.done   (alu_done),
		.res    (alu_res)
	);

	// Sequencer, configuration and integrator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b1;
			scan_q      <= SCAN_RESET;
			grav_q      <= GRAVITY_RESET;
			st_q        <= ST_IDLE;
			wait_q      <= 1'b0;
			k_q         <= '0;
			ax_q        <= '0;
			m_q         <= '0;
			dphase_q    <= 1'b0;
			have_last_q <= 1'b0;
			last_q      <= '0;
			integ_q     <= 1'b0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				ang_q[i] <= '0;
			end
		end else begin
			// Register writes.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENABLE:  enable_q <= cfg_data[0];
					REG_SCAN:    scan_q   <= cfg_data;
					REG_GRAVITY: grav_q   <= cfg_data[20:0];
					default:     ;
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (req.start) begin
				wait_q <= 1'b1;
			end else if (step_done) begin
				wait_q <= 1'b0;
			end

			case (st_q)
				ST_IDLE: begin
					if (in_acc && enable_q) begin
						last_q      <= time_us;
						have_last_q <= 1'b1;
						integ_q     <= integ_now;
						clip_q      <= 1'b0;
						k_q         <= '0;
						st_q        <= integ_now ? ST_QUAT : ST_OUT;
					end
				end
				ST_QUAT: begin
					if (step_done) begin
						if (k_q == 4'd8) begin
							k_q  <= '0;
							st_q <= ST_GRAV;
						end else begin
							k_q <= k_q + 4'd1;
						end
					end
				end
				ST_GRAV: begin
					if (step_done) begin
						if (k_q == 4'd2) begin
							k_q  <= '0;
							ax_q <= '0;
							st_q <= ST_ROT;
						end else begin
							k_q <= k_q + 4'd1;
						end
					end
				end
				ST_ROT: begin
					if (step_done) begin
						if (k_q == 4'd2) begin
							clip_q   <= clip_q | ovf32(s_next);
							m_q      <= '0;
							dphase_q <= 1'b0;
							st_q     <= ST_INT;
						end else begin
							k_q <= k_q + 4'd1;
						end
					end
				end
				ST_INT: begin
					if (step_done) begin
						dphase_q <= !dphase_q;
						if (dphase_q) begin
							m_q <= m_q + 2'd1;
							if (m_q == 2'd3) begin
								// Commit this axis.
								pos_q[ax_q] <= sat32(pos_sum);
								vel_q[ax_q] <= sat32(vel_sum);
								ang_q[ax_q] <= sat32(ang_sum);
								clip_q <= clip_q | ovf32(pos_sum) | ovf32(vel_sum)
									| ovf32(ang_sum);
								k_q <= '0;
								if (ax_q == 2'd2) begin
									st_q <= ST_OUT;
								end else begin
									ax_q <= ax_q + 2'd1;
									st_q <= ST_ROT;
								end
							end
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			qw_q        <= quat_w;
			qx_q        <= quat_x;
			qy_q        <= quat_y;
			qz_q        <= quat_z;
			acc_in_q[0] <= accel_x;
			acc_in_q[1] <= accel_y;
			acc_in_q[2] <= accel_z;
			gyr_q[0]    <= gyro_x;
			gyr_q[1]    <= gyro_y;
			gyr_q[2]    <= gyro_z;
			dt_q        <= diff[23:0];
		end
		if (step_done) begin
			case (st_q)
				ST_QUAT: p_q[k_q] <= alu_res[31:0];
				ST_GRAV: begin
					ac_q[k_q[1:0]] <= B_W'(RES_W'(acc_in_q[k_q[1:0]]) - round27(alu_res));
					s_q <= '0;
				end
				ST_ROT: begin
					s_q <= (k_q == 4'd2) ? '0 : s_next[SUM_W-1:0];
					if (k_q == 4'd2) begin
						aw_q <= sat32(s_next);
					end
				end
				ST_INT: begin
					if (dphase_q) begin
						case (m_q)
							2'd0:    dv_q <= alu_res[DELTA_W-1:0];
							2'd1:    pv_q <= alu_res[DELTA_W-1:0];
							2'd2:    pd_q <= alu_res[DELTA_W-1:0];
							default: s_q  <= '0;
						endcase
					end
				end
				default: ;
			endcase
		end
		if (st_q == ST_OUT && out_free) begin
			opos_q   <= pos_q;
			ovel_q   <= vel_q;
			oang_q   <= ang_q;
			ointeg_q <= integ_q;
			oclip_q  <= clip_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pos_x      = opos_q[0];
	assign pos_y      = opos_q[1];
	assign pos_z      = opos_q[2];
	assign vel_x      = ovel_q[0];
	assign vel_y      = ovel_q[1];
	assign vel_z      = ovel_q[2];
	assign rot_x      = oang_q[0];
	assign rot_y      = oang_q[1];
	assign rot_z      = oang_q[2];
	assign integrated = ointeg_q;
	assign saturated  = oclip_q;

endmodule

/* src/imudr_checker.sv */
// Port-level checks of the IMU dead-reckoning integrator and their binding.
module imudr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] vel_x,
	input logic signed [31:0] rot_x,
	input logic               integrated,
	input logic               saturated
);

	// A stalled result stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(vel_x)
			&& $stable(rot_x) && $stable(integrated) && $stable(saturated))
		else $error("result changed while stalled");

	// A held sample never reports clipping.
	a_held_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !integrated |-> !saturated)
		else $error("held sample reports saturation");

	// A new result only appears after the block was busy with its request.
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a busy cycle");

endmodule

bind imu_dead_reckoning_integrator_core imudr_checker u_imudr_checker (.*);
